[design/quad_x_motor_mixer_unit_macros.svh]
// Assertion helpers shared by the mixer modules.
`ifndef QUAD_X_MOTOR_MIXER_UNIT_MACROS_SVH
`define QUAD_X_MOTOR_MIXER_UNIT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define QXMM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("qxmm assertion failed");

// Consequent checked in the cycle after the antecedent.
`define QXMM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("qxmm assertion failed");

`endif

[design/qxmm_pkg.sv]
`default_nettype none

package qxmm_pkg;

    localparam int unsigned LATENCY = 6;

    typedef logic [10:0]        t_cmd;
    typedef logic signed [10:0] t_s11;
    typedef logic signed [11:0] t_s12;
    typedef logic signed [12:0] t_s13;
    typedef logic signed [13:0] t_mot;

    typedef enum logic [1:0] {
        REG_YAW_DIR = 2'd0,
        REG_MIN_THR = 2'd1,
        REG_MAX_THR = 2'd2,
        REG_MIN_CMD = 2'd3
    } t_reg_idx;

    localparam t_cmd RST_MIN_THR = 11'd1150;
    localparam t_cmd RST_MAX_THR = 11'd1850;
    localparam t_cmd RST_MIN_CMD = 11'd1000;
    localparam t_cmd YAW_MARGIN  = 11'd100;

    typedef struct packed {
        logic yaw_neg;
        t_cmd min_thr;
        t_cmd max_thr;
        t_cmd min_cmd;
    } t_cfg;

    typedef struct packed {
        logic valid;
        logic active;
        t_s11 yaw_lim;
        t_s12 yaw_term;
        t_s13 sum_plus;
        t_s13 sum_minus;
        t_s11 roll;
    } t_yaw_out;

    typedef struct packed {
        logic valid;
        logic active;
        t_s11 yaw_lim;
        t_mot m_rr;
        t_mot m_fr;
        t_mot m_rl;
        t_mot m_fl;
        t_mot m_max;
    } t_mix_out;

endpackage

`default_nettype wire

[design/qxmm_cfg.sv]
`default_nettype none

module qxmm_cfg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [10:0]       i_cfg_data,
    output qxmm_pkg::t_cfg    o_cfg
);

    logic           r_yaw_neg;
    qxmm_pkg::t_cmd r_min_thr;
    qxmm_pkg::t_cmd r_max_thr;
    qxmm_pkg::t_cmd r_min_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_yaw_neg <= 1'b0;
            r_min_thr <= qxmm_pkg::RST_MIN_THR;
            r_max_thr <= qxmm_pkg::RST_MAX_THR;
            r_min_cmd <= qxmm_pkg::RST_MIN_CMD;
        end else if (i_cfg_we) begin
            unique case (qxmm_pkg::t_reg_idx'(i_cfg_index))
                qxmm_pkg::REG_YAW_DIR: r_yaw_neg <= i_cfg_data[1];
                qxmm_pkg::REG_MIN_THR: r_min_thr <= i_cfg_data;
                qxmm_pkg::REG_MAX_THR: r_max_thr <= i_cfg_data;
                qxmm_pkg::REG_MIN_CMD: r_min_cmd <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg.yaw_neg = r_yaw_neg;
    assign o_cfg.min_thr = r_min_thr;
    assign o_cfg.max_thr = r_max_thr;
    assign o_cfg.min_cmd = r_min_cmd;

endmodule

`default_nettype wire

[design/qxmm_yaw.sv]
`default_nettype none
`include "quad_x_motor_mixer_unit_macros.svh"

module qxmm_yaw (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [10:0]         i_throttle_in,
    input  logic signed [10:0]  i_yaw_stick,
    input  logic signed [10:0]  i_pid_pitch,
    input  logic signed [10:0]  i_pid_roll,
    input  logic signed [10:0]  i_pid_yaw,
    input  logic                i_armed,
    input  logic                i_throttle_low,
    input  logic                i_yaw_neg,
    output qxmm_pkg::t_yaw_out  o_stage
);

    logic           r1_valid;
    logic           r1_active;
    logic [10:0]    r1_lim;
    qxmm_pkg::t_cmd r1_thr;
    qxmm_pkg::t_s11 r1_pitch;
    qxmm_pkg::t_s11 r1_roll;
    qxmm_pkg::t_s11 r1_yaw;

    logic [10:0]    n_abs;

    qxmm_pkg::t_s12 n_yaw12;
    qxmm_pkg::t_s12 n_lim12;
    qxmm_pkg::t_s12 n_clamped;
    qxmm_pkg::t_s12 n_term;
    qxmm_pkg::t_s13 n_thr13;
    qxmm_pkg::t_s13 n_pitch13;

    logic           r2_valid;
    logic           r2_active;
    qxmm_pkg::t_s11 r2_yaw_lim;
    qxmm_pkg::t_s12 r2_term;
    qxmm_pkg::t_s13 r2_plus;
    qxmm_pkg::t_s13 r2_minus;
    qxmm_pkg::t_s11 r2_roll;

    assign n_abs = i_yaw_stick[10] ? (~i_yaw_stick + 11'd1) : i_yaw_stick;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
        end
        r1_active <= i_armed & ~i_throttle_low;
        r1_lim    <= qxmm_pkg::YAW_MARGIN + n_abs;
        r1_thr    <= i_throttle_in;
        r1_pitch  <= i_pid_pitch;
        r1_roll   <= i_pid_roll;
        r1_yaw    <= i_pid_yaw;
    end

    always_comb begin
        n_yaw12 = {r1_yaw[10], r1_yaw};
        n_lim12 = {1'b0, r1_lim};
        if (n_yaw12 > n_lim12) begin
            n_clamped = n_lim12;
        end else if (n_yaw12 < -n_lim12) begin
            n_clamped = -n_lim12;
        end else begin
            n_clamped = n_yaw12;
        end
        n_term    = i_yaw_neg ? -n_clamped : n_clamped;
        n_thr13   = {2'b00, r1_thr};
        n_pitch13 = {{2{r1_pitch[10]}}, r1_pitch};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
        r2_active  <= r1_active;
        r2_yaw_lim <= r1_active ? n_clamped[10:0] : r1_yaw;
        r2_term    <= n_term;
        r2_plus    <= n_thr13 + n_pitch13;
        r2_minus   <= n_thr13 - n_pitch13;
        r2_roll    <= r1_roll;
    end

    assign o_stage.valid     = r2_valid;
    assign o_stage.active    = r2_active;
    assign o_stage.yaw_lim   = r2_yaw_lim;
    assign o_stage.yaw_term  = r2_term;
    assign o_stage.sum_plus  = r2_plus;
    assign o_stage.sum_minus = r2_minus;
    assign o_stage.roll      = r2_roll;

    `QXMM_ASSERT_NXT(a_yaw_within_limit, i_clk, i_rst_n, r1_valid && r1_active, ($signed({r2_yaw_lim[10], r2_yaw_lim}) <= $signed({1'b0, $past(r1_lim)})) && ($signed({r2_yaw_lim[10], r2_yaw_lim}) >= -$signed({1'b0, $past(r1_lim)})))

endmodule

`default_nettype wire

[design/qxmm_mix.sv]
`default_nettype none
`include "quad_x_motor_mixer_unit_macros.svh"

module qxmm_mix (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  qxmm_pkg::t_yaw_out  i_stage,
    output qxmm_pkg::t_mix_out  o_stage
);

    qxmm_pkg::t_mot n_plus;
    qxmm_pkg::t_mot n_minus;
    qxmm_pkg::t_mot n_roll;
    qxmm_pkg::t_mot n_yaw;

    logic           r3_valid;
    logic           r3_active;
    qxmm_pkg::t_s11 r3_yaw_lim;
    qxmm_pkg::t_mot r3_rr;
    qxmm_pkg::t_mot r3_fr;
    qxmm_pkg::t_mot r3_rl;
    qxmm_pkg::t_mot r3_fl;

    qxmm_pkg::t_mot n_max_r;
    qxmm_pkg::t_mot n_max_l;

    logic           r4_valid;
    logic           r4_active;
    qxmm_pkg::t_s11 r4_yaw_lim;
    qxmm_pkg::t_mot r4_rr;
    qxmm_pkg::t_mot r4_fr;
    qxmm_pkg::t_mot r4_rl;
    qxmm_pkg::t_mot r4_fl;
    qxmm_pkg::t_mot r4_max;

    always_comb begin
        n_plus  = {i_stage.sum_plus[12], i_stage.sum_plus};
        n_minus = {i_stage.sum_minus[12], i_stage.sum_minus};
        n_roll  = {{3{i_stage.roll[10]}}, i_stage.roll};
        n_yaw   = {{2{i_stage.yaw_term[11]}}, i_stage.yaw_term};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else begin
            r3_valid <= i_stage.valid;
        end
        r3_active  <= i_stage.active;
        r3_yaw_lim <= i_stage.yaw_lim;
        r3_rr      <= n_plus - n_roll + n_yaw;
        r3_fr      <= n_minus - n_roll - n_yaw;
        r3_rl      <= n_plus + n_roll - n_yaw;
        r3_fl      <= n_minus + n_roll + n_yaw;
    end

    always_comb begin
        n_max_r = (r3_rr >= r3_fr) ? r3_rr : r3_fr;
        n_max_l = (r3_rl >= r3_fl) ? r3_rl : r3_fl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else begin
            r4_valid <= r3_valid;
        end
        r4_active  <= r3_active;
        r4_yaw_lim <= r3_yaw_lim;
        r4_rr      <= r3_rr;
        r4_fr      <= r3_fr;
        r4_rl      <= r3_rl;
        r4_fl      <= r3_fl;
        r4_max     <= (n_max_r >= n_max_l) ? n_max_r : n_max_l;
    end

    assign o_stage.valid   = r4_valid;
    assign o_stage.active  = r4_active;
    assign o_stage.yaw_lim = r4_yaw_lim;
    assign o_stage.m_rr    = r4_rr;
    assign o_stage.m_fr    = r4_fr;
    assign o_stage.m_rl    = r4_rl;
    assign o_stage.m_fl    = r4_fl;
    assign o_stage.m_max   = r4_max;

    `QXMM_ASSERT_IMP(a_max_bounds_all, i_clk, i_rst_n, r4_valid, (r4_max >= r4_rr) && (r4_max >= r4_fr) && (r4_max >= r4_rl) && (r4_max >= r4_fl))
    `QXMM_ASSERT_IMP(a_max_is_member, i_clk, i_rst_n, r4_valid, (r4_max == r4_rr) || (r4_max == r4_fr) || (r4_max == r4_rl) || (r4_max == r4_fl))

endmodule

`default_nettype wire

[design/qxmm_lim.sv]
`default_nettype none
`include "quad_x_motor_mixer_unit_macros.svh"

module qxmm_lim (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  qxmm_pkg::t_mix_out  i_stage,
    input  qxmm_pkg::t_cfg      i_cfg,
    output logic                o_valid,
    output logic [10:0]         o_motor_rear_right,
    output logic [10:0]         o_motor_front_right,
    output logic [10:0]         o_motor_rear_left,
    output logic [10:0]         o_motor_front_left,
    output logic signed [10:0]  o_yaw_limited
);

    function automatic qxmm_pkg::t_cmd clamp_motor(
        input qxmm_pkg::t_mot m,
        input qxmm_pkg::t_mot diff,
        input qxmm_pkg::t_cmd lo,
        input qxmm_pkg::t_cmd hi
    );
        logic signed [14:0] v;
        logic signed [14:0] lo15;
        logic signed [14:0] hi15;
        qxmm_pkg::t_cmd     res;
        v    = {m[13], m} - {diff[13], diff};
        lo15 = {4'b0000, lo};
        hi15 = {4'b0000, hi};
        if (v < lo15) begin
            res = lo;
        end else if (v > hi15) begin
            res = hi;
        end else begin
            res = v[10:0];
        end
        return res;
    endfunction

    qxmm_pkg::t_mot n_max14;
    qxmm_pkg::t_mot n_excess;

    logic           r5_valid;
    logic           r5_active;
    qxmm_pkg::t_s11 r5_yaw_lim;
    qxmm_pkg::t_mot r5_rr;
    qxmm_pkg::t_mot r5_fr;
    qxmm_pkg::t_mot r5_rl;
    qxmm_pkg::t_mot r5_fl;
    qxmm_pkg::t_mot r5_diff;

    logic           r6_valid;
    logic           r6_active;
    qxmm_pkg::t_s11 r6_yaw_lim;
    qxmm_pkg::t_cmd r6_rr;
    qxmm_pkg::t_cmd r6_fr;
    qxmm_pkg::t_cmd r6_rl;
    qxmm_pkg::t_cmd r6_fl;

    always_comb begin
        n_max14  = {3'b000, i_cfg.max_thr};
        n_excess = i_stage.m_max - n_max14;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else begin
            r5_valid <= i_stage.valid;
        end
        r5_active  <= i_stage.active;
        r5_yaw_lim <= i_stage.yaw_lim;
        r5_rr      <= i_stage.m_rr;
        r5_fr      <= i_stage.m_fr;
        r5_rl      <= i_stage.m_rl;
        r5_fl      <= i_stage.m_fl;
        r5_diff    <= (i_stage.m_max > n_max14) ? n_excess : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_valid <= 1'b0;
        end else begin
            r6_valid <= r5_valid;
        end
        r6_active  <= r5_active;
        r6_yaw_lim <= r5_yaw_lim;
        if (r5_active) begin
            r6_rr <= clamp_motor(r5_rr, r5_diff, i_cfg.min_thr, i_cfg.max_thr);
            r6_fr <= clamp_motor(r5_fr, r5_diff, i_cfg.min_thr, i_cfg.max_thr);
            r6_rl <= clamp_motor(r5_rl, r5_diff, i_cfg.min_thr, i_cfg.max_thr);
            r6_fl <= clamp_motor(r5_fl, r5_diff, i_cfg.min_thr, i_cfg.max_thr);
        end else begin
            r6_rr <= i_cfg.min_cmd;
            r6_fr <= i_cfg.min_cmd;
            r6_rl <= i_cfg.min_cmd;
            r6_fl <= i_cfg.min_cmd;
        end
    end

    assign o_valid             = r6_valid;
    assign o_motor_rear_right  = r6_rr;
    assign o_motor_front_right = r6_fr;
    assign o_motor_rear_left   = r6_rl;
    assign o_motor_front_left  = r6_fl;
    assign o_yaw_limited       = r6_yaw_lim;

    `QXMM_ASSERT_IMP(a_idle_motors_equal, i_clk, i_rst_n, r6_valid && !r6_active, (r6_rr == r6_fr) && (r6_rl == r6_fl) && (r6_rr == r6_rl))

endmodule

`default_nettype wire

[design/quad_x_motor_mixer_unit.sv]
// Channel  | Signals                                          | Transfer
// ---------+--------------------------------------------------+-------------------------------
// frame in | start, busy, i_throttle_in .. i_throttle_low     | start high while busy is low
// result   | o_strobe, o_motor_*, o_yaw_limited               | o_strobe high for one cycle
// config   | i_cfg_we, i_cfg_index, i_cfg_data                | i_cfg_we high, no wait
//
// Six register stages: yaw range, yaw clamp and partial sums, motor sums,
// four-way maximum, excess over max_throttle, final clamp into the output register.
// Each accepted frame passes through the stages in order and yields one result; one frame per cycle.
// Synchronous reset clears the stage valid bits and loads the register defaults;
// busy stays high until the cycle after reset is released.
// No stalls: the pipeline always advances and results are never held.
`default_nettype none
`include "quad_x_motor_mixer_unit_macros.svh"

module quad_x_motor_mixer_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [10:0]         i_cfg_data,
    input  logic [10:0]         i_throttle_in,
    input  logic signed [10:0]  i_yaw_stick,
    input  logic signed [10:0]  i_pid_pitch,
    input  logic signed [10:0]  i_pid_roll,
    input  logic signed [10:0]  i_pid_yaw,
    input  logic                i_armed,
    input  logic                i_throttle_low,
    output logic                o_strobe,
    output logic [10:0]         o_motor_rear_right,
    output logic [10:0]         o_motor_front_right,
    output logic [10:0]         o_motor_rear_left,
    output logic [10:0]         o_motor_front_left,
    output logic signed [10:0]  o_yaw_limited
);

    logic               r_run;
    logic               accept;
    qxmm_pkg::t_cfg     cfg;
    qxmm_pkg::t_yaw_out yaw_stage;
    qxmm_pkg::t_mix_out mix_stage;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
        end else begin
            r_run <= 1'b1;
        end
    end

    assign busy   = ~r_run;
    assign accept = start & r_run;

    qxmm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    qxmm_yaw u_yaw (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (accept),
        .i_throttle_in  (i_throttle_in),
        .i_yaw_stick    (i_yaw_stick),
        .i_pid_pitch    (i_pid_pitch),
        .i_pid_roll     (i_pid_roll),
        .i_pid_yaw      (i_pid_yaw),
        .i_armed        (i_armed),
        .i_throttle_low (i_throttle_low),
        .i_yaw_neg      (cfg.yaw_neg),
        .o_stage        (yaw_stage)
    );

    qxmm_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stage (yaw_stage),
        .o_stage (mix_stage)
    );

    qxmm_lim u_lim (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_stage             (mix_stage),
        .i_cfg               (cfg),
        .o_valid             (o_strobe),
        .o_motor_rear_right  (o_motor_rear_right),
        .o_motor_front_right (o_motor_front_right),
        .o_motor_rear_left   (o_motor_rear_left),
        .o_motor_front_left  (o_motor_front_left),
        .o_yaw_limited       (o_yaw_limited)
    );

    `QXMM_ASSERT_IMP(a_strobe_follows_transfer, i_clk, i_rst_n, o_strobe, $past(accept, qxmm_pkg::LATENCY))

endmodule

`default_nettype wire

[verif/quad_x_motor_mixer_unit_tb.sv]
`default_nettype none

module quad_x_motor_mixer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned PHASES = 9;
    localparam int unsigned FRAMES_PER_PHASE = 205;
    localparam int unsigned IDLE_PERCENT = 10;
    localparam int unsigned QUIET_PHASE = 4;

    typedef struct packed {
        qxmm_pkg::t_cmd throttle;
        qxmm_pkg::t_s11 yaw_stick;
        qxmm_pkg::t_s11 pitch;
        qxmm_pkg::t_s11 roll;
        qxmm_pkg::t_s11 yaw;
        logic armed;
        logic thr_low;
    } t_frame;

    typedef struct packed {
        qxmm_pkg::t_cmd rr;
        qxmm_pkg::t_cmd fr;
        qxmm_pkg::t_cmd rl;
        qxmm_pkg::t_cmd fl;
        qxmm_pkg::t_s11 yaw_lim;
    } t_motor_cmds;

    class mixer_ledger;
        qxmm_pkg::t_cfg regs;
        t_motor_cmds pending_cmds[$];
        int unsigned mismatches;
        int unsigned frames_taken;
        int unsigned flying_frames;
        int unsigned cmds_checked;

        function new();
            regs.yaw_neg = 1'b0;
            regs.min_thr = qxmm_pkg::RST_MIN_THR;
            regs.max_thr = qxmm_pkg::RST_MAX_THR;
            regs.min_cmd = qxmm_pkg::RST_MIN_CMD;
            mismatches = 0;
            frames_taken = 0;
            flying_frames = 0;
            cmds_checked = 0;
        endfunction

        function void write_reg(qxmm_pkg::t_reg_idx idx, logic [10:0] data);
            case (idx)
                qxmm_pkg::REG_YAW_DIR: regs.yaw_neg = data[1];
                qxmm_pkg::REG_MIN_THR: regs.min_thr = data;
                qxmm_pkg::REG_MAX_THR: regs.max_thr = data;
                qxmm_pkg::REG_MIN_CMD: regs.min_cmd = data;
                default: ;
            endcase
        endfunction

        function t_motor_cmds mix_frame(t_frame f);
            t_motor_cmds r;
            qxmm_pkg::t_cmd mot[4];
            int m[4];
            int thr, stick, p, rl, yaw, lim, y, mx, diff, lo, hi, v;
            thr = int'(f.throttle);
            stick = int'($signed(f.yaw_stick));
            p = int'($signed(f.pitch));
            rl = int'($signed(f.roll));
            yaw = int'($signed(f.yaw));
            lo = int'(regs.min_thr);
            hi = int'(regs.max_thr);
            if (!f.armed || f.thr_low) begin
                r.rr = regs.min_cmd;
                r.fr = regs.min_cmd;
                r.rl = regs.min_cmd;
                r.fl = regs.min_cmd;
                r.yaw_lim = f.yaw;
                return r;
            end
            lim = int'(qxmm_pkg::YAW_MARGIN) + ((stick < 0) ? -stick : stick);
            if (yaw < -lim) begin
                yaw = -lim;
            end else if (yaw > lim) begin
                yaw = lim;
            end
            y = regs.yaw_neg ? -yaw : yaw;
            m[0] = thr + p - rl + y;
            m[1] = thr - p - rl - y;
            m[2] = thr + p + rl - y;
            m[3] = thr - p + rl + y;
            mx = m[0];
            for (int i = 1; i < 4; i++) begin
                if (m[i] > mx) begin
                    mx = m[i];
                end
            end
            diff = (mx > hi) ? mx - hi : 0;
            for (int i = 0; i < 4; i++) begin
                v = m[i] - diff;
                if (v < lo) begin
                    v = lo;
                end else if (v > hi) begin
                    v = hi;
                end
                mot[i] = qxmm_pkg::t_cmd'(v);
            end
            r.rr = mot[0];
            r.fr = mot[1];
            r.rl = mot[2];
            r.fl = mot[3];
            r.yaw_lim = qxmm_pkg::t_s11'(yaw);
            return r;
        endfunction

        function void note_frame(t_frame f);
            frames_taken++;
            if (f.armed && !f.thr_low) begin
                flying_frames++;
            end
            pending_cmds.push_back(mix_frame(f));
        endfunction

        function int unsigned pending();
            return pending_cmds.size();
        endfunction

        task report(string what, int got, int want);
            mismatches++;
            $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        endtask

        task check_cmds(t_motor_cmds got);
            t_motor_cmds want;
            if (pending_cmds.size() == 0) begin
                report("result with no frame outstanding", int'(got.rr), -1);
                return;
            end
            want = pending_cmds.pop_front();
            cmds_checked++;
            if (got.rr !== want.rr) report("rear right", int'(got.rr), int'(want.rr));
            if (got.fr !== want.fr) report("front right", int'(got.fr), int'(want.fr));
            if (got.rl !== want.rl) report("rear left", int'(got.rl), int'(want.rl));
            if (got.fl !== want.fl) report("front left", int'(got.fl), int'(want.fl));
            if (got.yaw_lim !== want.yaw_lim) begin
                report("yaw limited", int'($signed(got.yaw_lim)), int'($signed(want.yaw_lim)));
            end
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic start;
    logic busy;
    logic i_cfg_we;
    logic [1:0] i_cfg_index;
    logic [10:0] i_cfg_data;
    logic [10:0] i_throttle_in;
    logic signed [10:0] i_yaw_stick;
    logic signed [10:0] i_pid_pitch;
    logic signed [10:0] i_pid_roll;
    logic signed [10:0] i_pid_yaw;
    logic i_armed;
    logic i_throttle_low;
    logic o_strobe;
    logic [10:0] o_motor_rear_right;
    logic [10:0] o_motor_front_right;
    logic [10:0] o_motor_rear_left;
    logic [10:0] o_motor_front_left;
    logic signed [10:0] o_yaw_limited;

    mixer_ledger ledger = new();
    t_motor_cmds seen_cmds;
    t_frame taken_frame;
    int unsigned settings_used;

    quad_x_motor_mixer_unit DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_throttle_in      (i_throttle_in),
        .i_yaw_stick        (i_yaw_stick),
        .i_pid_pitch        (i_pid_pitch),
        .i_pid_roll         (i_pid_roll),
        .i_pid_yaw          (i_pid_yaw),
        .i_armed            (i_armed),
        .i_throttle_low     (i_throttle_low),
        .o_strobe           (o_strobe),
        .o_motor_rear_right (o_motor_rear_right),
        .o_motor_front_right(o_motor_front_right),
        .o_motor_rear_left  (o_motor_rear_left),
        .o_motor_front_left (o_motor_front_left),
        .o_yaw_limited      (o_yaw_limited)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (o_strobe === 1'b1) begin
                seen_cmds.rr = o_motor_rear_right;
                seen_cmds.fr = o_motor_front_right;
                seen_cmds.rl = o_motor_rear_left;
                seen_cmds.fl = o_motor_front_left;
                seen_cmds.yaw_lim = o_yaw_limited;
                ledger.check_cmds(seen_cmds);
            end
            if (start === 1'b1 && busy === 1'b0) begin
                taken_frame.throttle = i_throttle_in;
                taken_frame.yaw_stick = i_yaw_stick;
                taken_frame.pitch = i_pid_pitch;
                taken_frame.roll = i_pid_roll;
                taken_frame.yaw = i_pid_yaw;
                taken_frame.armed = i_armed;
                taken_frame.thr_low = i_throttle_low;
                ledger.note_frame(taken_frame);
            end
            if (i_cfg_we === 1'b1) begin
                ledger.write_reg(qxmm_pkg::t_reg_idx'(i_cfg_index), i_cfg_data);
            end
        end
    end

    function automatic t_frame mk(int thr, int stick, int p, int r, int y, bit armed, bit low);
        t_frame f;
        f.throttle = qxmm_pkg::t_cmd'(thr);
        f.yaw_stick = qxmm_pkg::t_s11'(stick);
        f.pitch = qxmm_pkg::t_s11'(p);
        f.roll = qxmm_pkg::t_s11'(r);
        f.yaw = qxmm_pkg::t_s11'(y);
        f.armed = armed;
        f.thr_low = low;
        return f;
    endfunction

    function automatic qxmm_pkg::t_s11 pick_s11();
        case ($urandom_range(0, 3))
            0: return qxmm_pkg::t_s11'($urandom_range(0, 2047));
            1: return qxmm_pkg::t_s11'(int'($urandom_range(0, 400)) - 200);
            2: return qxmm_pkg::t_s11'(int'($urandom_range(0, 1000)) - 500);
            default: begin
                case ($urandom_range(0, 3))
                    0: return qxmm_pkg::t_s11'(-1024);
                    1: return qxmm_pkg::t_s11'(1023);
                    2: return qxmm_pkg::t_s11'(-1);
                    default: return qxmm_pkg::t_s11'(0);
                endcase
            end
        endcase
    endfunction

    function automatic t_frame random_frame();
        t_frame f;
        case ($urandom_range(0, 3))
            0: f.throttle = qxmm_pkg::t_cmd'($urandom_range(0, 2047));
            1, 2: f.throttle = qxmm_pkg::t_cmd'($urandom_range(1000, 2000));
            default: f.throttle = ($urandom_range(0, 1) == 1) ? qxmm_pkg::t_cmd'(2047)
                                                              : qxmm_pkg::t_cmd'(0);
        endcase
        f.yaw_stick = pick_s11();
        f.pitch = pick_s11();
        f.roll = pick_s11();
        f.yaw = pick_s11();
        if ($urandom_range(0, 99) < 82) begin
            f.armed = 1'b1;
            f.thr_low = 1'b0;
        end else begin
            f.armed = 1'($urandom_range(0, 1));
            f.thr_low = 1'($urandom_range(0, 1));
        end
        return f;
    endfunction

    task automatic drive_fields(t_frame f);
        i_throttle_in <= f.throttle;
        i_yaw_stick <= f.yaw_stick;
        i_pid_pitch <= f.pitch;
        i_pid_roll <= f.roll;
        i_pid_yaw <= f.yaw;
        i_armed <= f.armed;
        i_throttle_low <= f.thr_low;
    endtask

    task automatic send_frame(t_frame f);
        start <= 1'b1;
        drive_fields(f);
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    // The fields carry noise while start is low; none of it may be taken.
    task automatic idle_cycles(int unsigned n);
        start <= 1'b0;
        drive_fields(random_frame());
        repeat (n) @(posedge i_clk);
    endtask

    task automatic maybe_idle(bit quiet);
        if (!quiet && $urandom_range(0, 99) < IDLE_PERCENT) begin
            idle_cycles($urandom_range(1, 3));
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (ledger.pending() != 0);
        repeat (qxmm_pkg::LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic cfg_write(qxmm_pkg::t_reg_idx idx, logic [10:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic load_regs(logic [1:0] yaw_code, qxmm_pkg::t_cmd mn, qxmm_pkg::t_cmd mx,
                             qxmm_pkg::t_cmd mc);
        cfg_write(qxmm_pkg::REG_YAW_DIR, {9'($urandom_range(0, 511)), yaw_code});
        cfg_write(qxmm_pkg::REG_MIN_THR, mn);
        cfg_write(qxmm_pkg::REG_MAX_THR, mx);
        cfg_write(qxmm_pkg::REG_MIN_CMD, mc);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    initial begin
        #2_000_000;
        $display("quad_x_motor_mixer_unit_tb: FAIL");
        $finish;
    end

    initial begin
        t_frame directed[$];
        i_rst_n = 1'b0;
        start = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = 2'd0;
        i_cfg_data = 11'd0;
        i_throttle_in = 11'd0;
        i_yaw_stick = 11'sd0;
        i_pid_pitch = 11'sd0;
        i_pid_roll = 11'sd0;
        i_pid_yaw = 11'sd0;
        i_armed = 1'b0;
        i_throttle_low = 1'b0;
        settings_used = 1;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        directed.push_back(mk(2047, -1024, 1023, -1024, 1023, 0, 0));
        directed.push_back(mk(0, 1023, -1024, 1023, -1024, 0, 1));
        directed.push_back(mk(1500, 0, 0, 0, 500, 1, 1));
        directed.push_back(mk(1500, 0, 0, 0, 0, 1, 0));
        directed.push_back(mk(1500, 0, 0, 0, 1023, 1, 0));
        directed.push_back(mk(1500, 0, 0, 0, -1024, 1, 0));
        directed.push_back(mk(1500, -1024, 0, 0, 1023, 1, 0));
        directed.push_back(mk(1500, 300, 0, 0, -1024, 1, 0));
        directed.push_back(mk(2047, 0, 200, 100, 50, 1, 0));
        directed.push_back(mk(0, 0, -100, 50, 20, 1, 0));
        directed.push_back(mk(2047, 1023, 1023, 1023, 1023, 1, 0));
        directed.push_back(mk(0, -1024, -1024, -1024, -1024, 1, 0));
        directed.push_back(mk(2047, -1024, -1024, 1023, -1024, 1, 0));
        directed.push_back(mk(1200, 500, 300, -300, 200, 1, 0));
        directed.push_back(mk(1850, 0, 0, 0, 0, 1, 0));
        directed.push_back(mk(1851, 0, 0, 0, 0, 1, 0));
        directed.push_back(mk(1150, 0, 0, 0, 0, 1, 0));
        directed.push_back(mk(1149, -1, 1, -1, 1, 1, 0));
        directed.push_back(mk(1024, 1023, 512, -512, -1024, 1, 0));
        directed.push_back(mk(1700, 0, -700, 700, 99, 1, 0));
        foreach (directed[i]) begin
            send_frame(directed[i]);
            maybe_idle(1'b0);
        end

        for (int unsigned ph = 0; ph < PHASES; ph++) begin
            if (ph != 0) begin
                drain();
                case (ph)
                    1: load_regs(2'b11, qxmm_pkg::t_cmd'(0), qxmm_pkg::t_cmd'(2047),
                                 qxmm_pkg::t_cmd'(0));
                    2: load_regs(2'b00, qxmm_pkg::t_cmd'(2047), qxmm_pkg::t_cmd'(0),
                                 qxmm_pkg::t_cmd'(2047));
                    3: load_regs(2'b10, qxmm_pkg::RST_MIN_THR, qxmm_pkg::RST_MAX_THR,
                                 qxmm_pkg::RST_MIN_CMD);
                    QUIET_PHASE: load_regs(2'b01, qxmm_pkg::t_cmd'($urandom_range(1000, 1300)),
                                           qxmm_pkg::t_cmd'($urandom_range(1700, 2047)),
                                           qxmm_pkg::t_cmd'($urandom_range(900, 1100)));
                    default: begin
                        if ($urandom_range(0, 1) == 1) begin
                            load_regs(2'($urandom_range(0, 3)),
                                      qxmm_pkg::t_cmd'($urandom_range(0, 2047)),
                                      qxmm_pkg::t_cmd'($urandom_range(0, 2047)),
                                      qxmm_pkg::t_cmd'($urandom_range(0, 2047)));
                        end else begin
                            load_regs(2'($urandom_range(0, 3)),
                                      qxmm_pkg::t_cmd'($urandom_range(1000, 1300)),
                                      qxmm_pkg::t_cmd'($urandom_range(1600, 2000)),
                                      qxmm_pkg::t_cmd'($urandom_range(800, 1200)));
                        end
                    end
                endcase
            end
            for (int unsigned n = 0; n < FRAMES_PER_PHASE; n++) begin
                send_frame(random_frame());
                maybe_idle(ph == QUIET_PHASE);
            end
        end

        drain();
        $display("Sent %0d frames (%0d flying) across %0d register settings; %0d results checked.",
                 ledger.frames_taken, ledger.flying_frames, settings_used, ledger.cmds_checked);
        $display("Settings included both yaw signs, crossed throttle limits and full-scale values.");
        if (ledger.mismatches == 0) begin
            $display("quad_x_motor_mixer_unit_tb: PASS");
        end else begin
            $display("quad_x_motor_mixer_unit_tb: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
